### rtl/time_slice_task_scheduler_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the time-slice task scheduler
// Shared property wrappers, clocked on the rising edge, reset gated.
// -----------------------------------------------------------------------------
`ifndef TIME_SLICE_TASK_SCHEDULER_ASSERT_SVH
`define TIME_SLICE_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define TSTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tsts_pkg.sv
// -----------------------------------------------------------------------------
// tsts_pkg
// Types and constants shared by the task scheduler controller and slot cells.
// -----------------------------------------------------------------------------
package tsts_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int SLICE_W       = 8;
   localparam int SLEEP_W       = 16;
   localparam int OUT_SLOT_W    = 3;
   localparam logic [SLICE_W-1:0]    SLICE_RESET = 8'd16;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SLICE  = 2'd0;

   typedef enum logic [1:0] {
      SLOT_FREE  = 2'd0,
      SLOT_READY = 2'd1,
      SLOT_RUN   = 2'd2,
      SLOT_SLEEP = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_FORK  = 2'd1,
      MODE_SLEEP = 2'd2,
      MODE_EXIT  = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   // broadcast from controller to every cell
   typedef struct packed {
      logic               load;
      mode_type           mode;
      logic [SLEEP_W-1:0] sleep_ticks;
   } event_type;

   // token flags handed from cell to cell
   typedef struct packed {
      logic           valid;
      logic           found;
      slot_state_type cur_st;
      logic           expired;
   } token_type;

   // end-of-walk update
   typedef struct packed {
      logic valid;
      logic do_switch;
   } commit_type;

endpackage

### rtl/tsts_cell.sv
// -----------------------------------------------------------------------------
// tsts_cell
// One task slot: status, sleep countdown, slice count. Acts on the load event,
// on the commit and when the token passes, handing the token to the next slot.
// -----------------------------------------------------------------------------
module tsts_cell #(
   parameter int SLOTS    = 8,
   parameter int CELL_IDX = 0,
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tsts_pkg::event_type               evt,
   input  logic [IDX_W-1:0]                  cur,
   input  logic [tsts_pkg::SLICE_W-1:0]      slice_ticks,
   input  tsts_pkg::token_type               tok_in,
   input  logic [IDX_W-1:0]                  pick_in,
   input  tsts_pkg::commit_type              commit,
   input  logic [IDX_W-1:0]                  commit_pick,
   output tsts_pkg::token_type               tok_out,
   output logic [IDX_W-1:0]                  pick_out
);
   import tsts_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_IDX);
   localparam bit               IS_IDLE = (CELL_IDX == 0);

   slot_state_type     st_ff, st_in, st_w;
   logic [SLEEP_W-1:0] sleep_ff, sleep_in, sleep_w;
   logic [SLICE_W-1:0] used_ff, used_in, used_w;
   token_type          tok_ff, tok_in_nx;
   logic [IDX_W-1:0]   pick_ff, pick_in_nx;
   logic               is_cur;

   assign is_cur = (cur == MY_IDX);

   // wake and slice charge as seen during a non-fork visit
   always_comb begin
      st_w    = st_ff;
      sleep_w = sleep_ff;
      if (!IS_IDLE && st_ff == SLOT_SLEEP) begin
         if (sleep_ff > SLEEP_W'(1)) begin
            sleep_w = sleep_ff - SLEEP_W'(1);
         end else begin
            sleep_w = '0;
            st_w    = SLOT_READY;
         end
      end
      used_w = used_ff;
      if (is_cur && used_ff != {SLICE_W{1'b1}}) begin
         used_w = used_ff + SLICE_W'(1);
      end
   end

   always_comb begin
      st_in      = st_ff;
      sleep_in   = sleep_ff;
      used_in    = used_ff;
      tok_in_nx  = tok_in;
      pick_in_nx = pick_in;
      if (evt.load) begin
         if (is_cur && evt.mode == MODE_SLEEP) begin
            st_in    = SLOT_SLEEP;
            sleep_in = evt.sleep_ticks;
         end else if (is_cur && evt.mode == MODE_EXIT) begin
            st_in = SLOT_FREE;
         end
      end else if (tok_in.valid) begin
         if (evt.mode == MODE_FORK) begin
            if (!IS_IDLE && st_ff == SLOT_FREE && !tok_in.found) begin
               st_in           = SLOT_READY;
               sleep_in        = '0;
               used_in         = '0;
               tok_in_nx.found = 1'b1;
               pick_in_nx      = MY_IDX;
            end
         end else begin
            st_in    = st_w;
            sleep_in = sleep_w;
            used_in  = used_w;
            if (is_cur) begin
               tok_in_nx.cur_st  = st_w;
               tok_in_nx.expired = (used_w >= slice_ticks);
            end
            if (!IS_IDLE && !is_cur && st_w == SLOT_READY && !tok_in.found) begin
               tok_in_nx.found = 1'b1;
               pick_in_nx      = MY_IDX;
            end
         end
      end else if (commit.valid && commit.do_switch) begin
         if (is_cur && st_ff == SLOT_RUN) begin
            st_in   = SLOT_READY;
            used_in = '0;
         end
         if (commit_pick == MY_IDX) begin
            st_in = SLOT_RUN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= IS_IDLE ? SLOT_RUN : SLOT_FREE;
         sleep_ff <= '0;
         used_ff  <= '0;
         tok_ff   <= '0;
         pick_ff  <= '0;
      end else begin
         st_ff    <= st_in;
         sleep_ff <= sleep_in;
         used_ff  <= used_in;
         tok_ff   <= tok_in_nx;
         pick_ff  <= pick_in_nx;
      end
   end

   assign tok_out  = tok_ff;
   assign pick_out = pick_ff;

endmodule

### rtl/tsts_ctrl.sv
// -----------------------------------------------------------------------------
// tsts_ctrl
// Request sequencing, slice register, current slot and result registers.
// -----------------------------------------------------------------------------
module tsts_ctrl #(
   parameter int SLOTS  = 8,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  tsts_pkg::mode_type                   req_mode,
   input  logic [tsts_pkg::SLEEP_W-1:0]         req_sleep_ticks,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tsts_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [tsts_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tsts_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output tsts_pkg::event_type                  evt,
   output logic [IDX_W-1:0]                     cur,
   output logic [tsts_pkg::SLICE_W-1:0]         slice_ticks,
   output tsts_pkg::token_type                  tok_launch,
   output logic [IDX_W-1:0]                     pick_launch,
   input  tsts_pkg::token_type                  tok_last,
   input  logic [IDX_W-1:0]                     pick_last,
   output tsts_pkg::commit_type                 commit,
   output logic [IDX_W-1:0]                     commit_pick,
   output logic                                 rsp_valid,
   output logic [tsts_pkg::OUT_SLOT_W-1:0]      rsp_running_slot,
   output logic                                 rsp_switched,
   output logic                                 rsp_fork_ok,
   output logic [tsts_pkg::OUT_SLOT_W-1:0]      rsp_child_slot
);
   import tsts_pkg::*;

   localparam int EXT_W = IDX_W + OUT_SLOT_W;

   state_type                state_ff, state_in;
   mode_type                 mode_ff;
   logic [IDX_W-1:0]         cur_ff, cur_in;
   logic [SLICE_W-1:0]       slice_ff;
   logic                     launch_ff;
   logic                     accept, done, is_fork;
   logic                     rsp_valid_ff;
   logic [OUT_SLOT_W-1:0]    run_ff, child_ff;
   logic                     sw_ff, ok_ff;
   logic [EXT_W-1:0]         run_ext, child_ext;

   assign accept  = start && (state_ff == ST_IDLE);
   assign done    = tok_last.valid;
   assign is_fork = (mode_ff == MODE_FORK);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_WALK: busy = 1'b1;
         default: busy = 1'b0;
      endcase
   end

   always_comb begin
      evt.load        = accept;
      evt.mode        = accept ? req_mode : mode_ff;
      evt.sleep_ticks = req_sleep_ticks;
   end

   always_comb begin
      tok_launch.valid   = launch_ff;
      tok_launch.found   = 1'b0;
      tok_launch.cur_st  = SLOT_FREE;
      tok_launch.expired = 1'b0;
   end
   assign pick_launch = '0;

   // end of walk: decide the switch
   always_comb begin
      commit.valid     = done;
      commit.do_switch = !is_fork &&
                         (tok_last.expired || tok_last.cur_st == SLOT_FREE ||
                          tok_last.cur_st == SLOT_SLEEP || cur_ff == '0);
      commit_pick      = tok_last.found ? pick_last : '0;
      cur_in           = commit.do_switch ? commit_pick : cur_ff;
   end

   assign run_ext   = {{OUT_SLOT_W{1'b0}}, cur_in};
   assign child_ext = {{OUT_SLOT_W{1'b0}}, commit_pick};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         slice_ff     <= SLICE_RESET;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= accept;
         rsp_valid_ff <= done;
         if (done) cur_ff <= cur_in;
         if (psel && penable && pwrite && paddr == ADDR_SLICE) begin
            slice_ff <= pwdata[SLICE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) mode_ff <= req_mode;
      if (done) begin
         run_ff   <= run_ext[OUT_SLOT_W-1:0];
         sw_ff    <= (cur_in != cur_ff);
         ok_ff    <= is_fork && tok_last.found;
         child_ff <= (is_fork && tok_last.found) ? child_ext[OUT_SLOT_W-1:0] : '0;
      end
   end

   assign cur              = cur_ff;
   assign slice_ticks      = slice_ff;
   assign pready           = 1'b1;
   assign prdata           = (paddr == ADDR_SLICE) ? CSR_DATA_W'(slice_ff) : '0;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_slot = run_ff;
   assign rsp_switched     = sw_ff;
   assign rsp_fork_ok      = ok_ff;
   assign rsp_child_slot   = child_ff;

endmodule

### rtl/time_slice_task_scheduler.sv
// -----------------------------------------------------------------------------
// time_slice_task_scheduler
// Preemptive time-slice scheduler over a row of task-slot cells.
// -----------------------------------------------------------------------------
// A request (start high while busy is low) is one scheduling event: tick,
// fork, sleep or exit. Each request produces exactly one result, shown on the
// rsp_ ports for a single cycle with rsp_valid high; the receiver cannot stall
// it, so sample it when the strobe is seen. The result is registered at the
// end of the token walk, and busy is low in the same cycle as the strobe, so
// a new request can be taken while the result is shown, but not before. The
// walk runs from the launch register through one cell per slot, the token
// moving one cell per clock; the switch is committed as the result registers
// are loaded. The slice length register sits at byte address 0 of the
// APB-style port and should only be written while busy is low.
// -----------------------------------------------------------------------------
module time_slice_task_scheduler #(
   parameter int SLOTS  = tsts_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_mode,
   input  logic [tsts_pkg::SLEEP_W-1:0]         req_sleep_ticks,
   // result channel
   output logic                                 rsp_valid,
   output logic [tsts_pkg::OUT_SLOT_W-1:0]      rsp_running_slot,
   output logic                                 rsp_switched,
   output logic                                 rsp_fork_ok,
   output logic [tsts_pkg::OUT_SLOT_W-1:0]      rsp_child_slot,
   // configuration
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tsts_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [tsts_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tsts_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import tsts_pkg::*;

   // Shared broadcasts to all cells: event (with the load pulse that applies
   // sleep/exit to the current slot), current slot and slice length.
   event_type          evt;
   logic [IDX_W-1:0]   cur;
   logic [SLICE_W-1:0] slice_ticks;
   commit_type         commit;
   logic [IDX_W-1:0]   commit_pick;

   // Token chain: entry 0 is the launch register, entry k+1 the output of
   // cell k. The token carries the search result and what the current
   // slot's cell saw on its visit (status after wake, slice expired).
   token_type          tok   [SLOTS+1];
   logic [IDX_W-1:0]   pick  [SLOTS+1];

   tsts_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (mode_type'(req_mode)),
      .req_sleep_ticks  (req_sleep_ticks),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .evt              (evt),
      .cur              (cur),
      .slice_ticks      (slice_ticks),
      .tok_launch       (tok[0]),
      .pick_launch      (pick[0]),
      .tok_last         (tok[SLOTS]),
      .pick_last        (pick[SLOTS]),
      .commit           (commit),
      .commit_pick      (commit_pick),
      .rsp_valid        (rsp_valid),
      .rsp_running_slot (rsp_running_slot),
      .rsp_switched     (rsp_switched),
      .rsp_fork_ok      (rsp_fork_ok),
      .rsp_child_slot   (rsp_child_slot)
   );

   // One cell per slot; slot 0 is the idle task and never wakes or gets
   // picked by the search, but it is charged ticks and can be switched.
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      tsts_cell #(
         .SLOTS    (SLOTS),
         .CELL_IDX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .evt         (evt),
         .cur         (cur),
         .slice_ticks (slice_ticks),
         .tok_in      (tok[k]),
         .pick_in     (pick[k]),
         .commit      (commit),
         .commit_pick (commit_pick),
         .tok_out     (tok[k+1]),
         .pick_out    (pick[k+1])
      );
   end

endmodule

### rtl/tsts_checker.sv
// -----------------------------------------------------------------------------
// tsts_checker
// Port-level checks on the scheduler's request and result channels.
// -----------------------------------------------------------------------------
`include "time_slice_task_scheduler_assert.svh"

module tsts_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_switched,
   input logic       rsp_fork_ok,
   input logic [2:0] rsp_child_slot
);

   // a request makes the block busy
   `TSTS_ASSERT_NXT(a_busy_after_req, clock, reset, start && !busy, busy, "busy not raised")

   // results never come back to back
   `TSTS_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "double result strobe")

   // busy ends exactly with the result strobe
   `TSTS_ASSERT_IMP(a_done_rsp, clock, reset, !$past(reset) && $fell(busy), rsp_valid, "busy fell without result")

   // failed forks and non-forks report no child
   `TSTS_ASSERT_IMP(a_child_zero, clock, reset, rsp_valid && !rsp_fork_ok, rsp_child_slot == 3'd0, "child slot without fork")

   // a fork never moves the processor
   `TSTS_ASSERT_IMP(a_fork_noswitch, clock, reset, rsp_valid && rsp_fork_ok, !rsp_switched, "fork switched slot")

endmodule

bind time_slice_task_scheduler tsts_checker u_tsts_checker (.*);
